FILE: rtl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Types and codes shared by the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package mpq_pkg;

	localparam int COST_W = 16;
	localparam int IDENT_W = 16;
	localparam int PAYLOAD_W = 32;
	localparam int KEY_W = COST_W + IDENT_W;
	localparam int ENTRY_W = KEY_W + PAYLOAD_W;

	typedef logic [KEY_W-1:0] key_t;

	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic [IDENT_W-1:0] ident;
		logic [PAYLOAD_W-1:0] payload;
	} entry_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_POP = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_POPPED = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_FULL = 3'd3,
		ST_EMPTY = 3'd4
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_APPLY = 1'b1
	} fsm_t;

	// Strobes broadcast to every cell of the row
	typedef struct packed {
		logic cmp;
		logic ins;
		logic pop;
	} cell_ctl_t;

	function automatic key_t key_of(entry_t e);
		return {e.cost, e.ident};
	endfunction

endpackage

FILE: rtl/mpq_cell.sv
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted row: compares, then keeps, takes or shifts.
// ----------------------------------------------------------------------------
module mpq_cell import mpq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      valid,
	input  key_t      cmp_key,
	input  entry_t    new_entry,
	input  entry_t    left_entry,
	input  logic      left_lt,
	input  entry_t    right_entry,
	output entry_t    entry,
	output logic      lt,
	output logic      eq
);

	entry_t entry_q;
	logic   lt_q;
	logic   eq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.cmp) begin
			lt_q <= valid && (key_of(entry_q) < cmp_key);
			eq_q <= valid && (key_of(entry_q) == cmp_key);
		end
	end

	// On a pop take the entry from the right; on an insert keep when below the
	// new key, take the new entry at the boundary, otherwise shift in from the left.
	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			entry_q <= right_entry;
		end else if (ctl.ins && !lt_q) begin
			entry_q <= left_lt ? new_entry : left_entry;
		end
	end

	assign entry = entry_q;
	assign lt = lt_q;
	assign eq = eq_q;

endmodule

FILE: rtl/min_priority_queue_f_then_id.sv
// ----------------------------------------------------------------------------
// min_priority_queue_f_then_id
// Sorted open-list priority queue for best-first search, built as a row of
// cells ordered by (cost, ident).
// ----------------------------------------------------------------------------
// Each input transfer is either an insert (s_tuser = 0) of a node with cost,
// ident and payload, or a pop (s_tuser = 1) of the entry with the least
// (cost, ident). Every item gives exactly one result transfer whose tuser
// carries a status: inserted, popped, duplicate ignored (same cost and ident
// already stored), full dropped, or empty pop. Cost, ident and payload of the
// result are zero unless an entry was popped; the occupancy after the item
// is always reported. At the accepting edge every cell compares its stored
// key with the incoming key in parallel; then, in the apply state, the cells
// keep, take the new entry or shift by one place to their neighbour, and
// the result is loaded into the output register. s_tready is low in the
// apply state, so the block takes no new item until it is through with the
// last. The output register lets the next item be accepted while a result
// still waits; that item's apply cycle holds until the result is taken.
// The row holds CAPACITY entries; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module min_priority_queue_f_then_id import mpq_pkg::*; #(
	parameter int CAPACITY = 16,
	localparam int OCC_W = $clog2(CAPACITY + 1),
	localparam int M_W = ((ENTRY_W + OCC_W + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [63:0]    s_tdata,  // node_cost, node_ident, node_payload
	input  logic           s_tuser,  // operation
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [M_W-1:0] m_tdata,  // out_cost, out_ident, out_payload, occupancy
	output logic [2:0]     m_tuser   // status
);

	fsm_t              state_q;
	fsm_t              state_d;
	logic              accept;
	logic              apply_en;
	op_t               cmd_op_q;
	entry_t            cmd_entry_q;
	entry_t            in_entry;
	logic [OCC_W-1:0]  count_q;
	logic [OCC_W-1:0]  count_d;
	logic              dup;
	logic              full;
	logic              empty;
	cell_ctl_t         ctl;

	entry_t            cell_entry [CAPACITY];
	logic [CAPACITY-1:0] cell_lt;
	logic [CAPACITY-1:0] cell_eq;

	logic              out_valid_q;
	status_t           out_status_q;
	status_t           status_d;
	entry_t            out_entry_q;
	logic [OCC_W-1:0]  out_occ_q;

	// Unpack the input fields, lowest first
	assign in_entry.cost = s_tdata[15:0];
	assign in_entry.ident = s_tdata[31:16];
	assign in_entry.payload = s_tdata[63:32];

	// ------------------------------------------------------------------
	// Sequencer: accept (cells compare) then apply (cells move)
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (s_tvalid) begin
					state_d = FSM_APPLY;
				end
			end
			FSM_APPLY: begin
				if (!out_valid_q || m_tready) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		apply_en = 1'b0;
		case (state_q)
			FSM_IDLE: s_tready = 1'b1;
			FSM_APPLY: apply_en = !out_valid_q || m_tready;
			default: s_tready = 1'b0;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	// Hold the command for the apply cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_op_q <= OP_INSERT;
		end else if (accept) begin
			cmd_op_q <= op_t'(s_tuser);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_entry_q <= in_entry;
		end
	end

	// ------------------------------------------------------------------
	// Decisions taken from the registered compare flags
	// ------------------------------------------------------------------
	assign dup = |cell_eq;
	assign full = (count_q == OCC_W'(CAPACITY));
	assign empty = (count_q == '0);

	assign ctl.cmp = accept;
	assign ctl.ins = apply_en && (cmd_op_q == OP_INSERT) && !dup && !full;
	assign ctl.pop = apply_en && (cmd_op_q == OP_POP) && !empty;

	always_comb begin
		count_d = count_q;
		if (ctl.ins) begin
			count_d = count_q + OCC_W'(1);
		end else if (ctl.pop) begin
			count_d = count_q - OCC_W'(1);
		end
	end

	always_comb begin
		if (cmd_op_q == OP_POP) begin
			status_d = empty ? ST_EMPTY : ST_POPPED;
		end else if (dup) begin
			status_d = ST_DUPLICATE;
		end else if (full) begin
			status_d = ST_FULL;
		end else begin
			status_d = ST_INSERTED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (apply_en) begin
			count_q <= count_d;
		end
	end

	// ------------------------------------------------------------------
	// Row of cells; cell 0 holds the least key. Its left neighbour is the
	// new entry itself with no "below" flag, so it takes it when not kept.
	// ------------------------------------------------------------------
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_entry;
		logic   left_lt;
		entry_t right_entry;

		if (i == 0) begin : g_first
			assign left_entry = cmd_entry_q;
			assign left_lt = 1'b0;
		end else begin : g_mid
			assign left_entry = cell_entry[i-1];
			assign left_lt = cell_lt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_entry = cell_entry[i];
		end else begin : g_inner
			assign right_entry = cell_entry[i+1];
		end

		mpq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.valid      (OCC_W'(i) < count_q),
			.cmp_key    (key_of(in_entry)),
			.new_entry  (cmd_entry_q),
			.left_entry (left_entry),
			.left_lt    (left_lt),
			.right_entry(right_entry),
			.entry      (cell_entry[i]),
			.lt         (cell_lt[i]),
			.eq         (cell_eq[i])
		);
	end

	// ------------------------------------------------------------------
	// Output register: load on apply, drop valid once transferred
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_status_q <= ST_INSERTED;
		end else if (apply_en) begin
			out_valid_q <= 1'b1;
			out_status_q <= status_d;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_en) begin
			out_entry_q <= (status_d == ST_POPPED) ? cell_entry[0] : '0;
			out_occ_q <= count_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_status_q;

	always_comb begin
		m_tdata = '0;
		m_tdata[15:0] = out_entry_q.cost;
		m_tdata[31:16] = out_entry_q.ident;
		m_tdata[63:32] = out_entry_q.payload;
		m_tdata[ENTRY_W +: OCC_W] = out_occ_q;
	end

endmodule

FILE: rtl/mpq_checker.sv
// ----------------------------------------------------------------------------
// mpq_checker
// Port-level checks on the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module mpq_checker import mpq_pkg::*; #(
	parameter int CAPACITY = 16,
	localparam int OCC_W = $clog2(CAPACITY + 1),
	localparam int M_W = ((ENTRY_W + OCC_W + 7) / 8) * 8
) (
	input logic           clk,
	input logic           arst_n,
	input logic           s_tvalid,
	input logic           s_tready,
	input logic           m_tvalid,
	input logic           m_tready,
	input logic [M_W-1:0] m_tdata,
	input logic [2:0]     m_tuser
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// One item at a time: no transfer in the cycle after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken in the apply cycle");

	// Only a pop carries an entry
	a_zero_entry: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_POPPED) |-> m_tdata[ENTRY_W-1:0] == '0)
		else $error("entry fields not zero on a non-pop result");

	// Empty pop reports an empty store
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_EMPTY) |-> m_tdata[ENTRY_W +: OCC_W] == '0)
		else $error("empty pop with non-zero occupancy");

	// A full drop reports a full store
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_FULL) |-> m_tdata[ENTRY_W +: OCC_W] == OCC_W'(CAPACITY))
		else $error("full drop below capacity");

endmodule

bind min_priority_queue_f_then_id mpq_checker #(.CAPACITY(CAPACITY)) u_mpq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

FILE: bench/tb_min_priority_queue_f_then_id.sv
// ----------------------------------------------------------------------------
// tb_min_priority_queue_f_then_id
// Self-checking bench for the sorted open-list priority queue.
// ----------------------------------------------------------------------------
// A short table of directed items covers the empty pop, the key extremes,
// duplicate keys, ordering on cost and then ident, and the full store.
// Random inserts and pops follow, in phases with and without idling on either
// stream. A long hold-off on the result stream fills the block until its
// input stalls. The bench keeps its own sorted copy of the open list, works
// out every result when an item transfer is accepted, and compares each
// result transfer field by field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module tb_min_priority_queue_f_then_id;
	import mpq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY = 16;
	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam int M_W = ((ENTRY_W + OCC_W + 7) / 8) * 8;
	localparam int PHASE_ITEMS = 500;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_REPORTS = 10;

	// One result as the block should deliver it
	typedef struct {
		status_t status;
		logic [COST_W-1:0] cost;
		logic [IDENT_W-1:0] ident;
		logic [PAYLOAD_W-1:0] payload;
		logic [OCC_W-1:0] occ;
	} qresult_t;

	// One row of the directed table; typed rows carry their own result
	typedef struct {
		op_t op;
		logic [COST_W-1:0] cost;
		logic [IDENT_W-1:0] ident;
		logic [PAYLOAD_W-1:0] payload;
		bit typed;
		status_t status;
		logic [COST_W-1:0] r_cost;
		logic [IDENT_W-1:0] r_ident;
		logic [PAYLOAD_W-1:0] r_payload;
		logic [OCC_W-1:0] r_occ;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;    // node_cost, node_ident, node_payload
	logic s_tuser = 1'b0;         // operation
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_W-1:0] m_tdata;      // out_cost, out_ident, out_payload, occupancy
	logic [2:0] m_tuser;          // status

	// Bench copy of the open list, kept ascending by (cost, ident)
	entry_t open_list[$];
	qresult_t pending_results[$];
	int fault_count = 0;

	// Idling controls, set by the stimulus process per phase
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;

	dir_row_t directed_rows[25] = '{
		// empty pop straight after reset
		'{OP_POP, 16'h0000, 16'h0000, 32'h0, 1'b1, ST_EMPTY, 16'h0, 16'h0, 32'h0, 5'd0},
		// largest key and payload
		'{OP_INSERT, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
			1'b1, ST_INSERTED, 16'h0, 16'h0, 32'h0, 5'd1},
		// same key, other payload: rejected
		'{OP_INSERT, 16'hFFFF, 16'hFFFF, 32'h0000_0000,
			1'b1, ST_DUPLICATE, 16'h0, 16'h0, 32'h0, 5'd1},
		// least key
		'{OP_INSERT, 16'h0000, 16'h0000, 32'h0000_0000,
			1'b1, ST_INSERTED, 16'h0, 16'h0, 32'h0, 5'd2},
		'{OP_POP, 16'h0000, 16'h0000, 32'h0, 1'b1, ST_POPPED, 16'h0, 16'h0, 32'h0, 5'd1},
		'{OP_POP, 16'h0000, 16'h0000, 32'h0,
			1'b1, ST_POPPED, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 5'd0},
		'{OP_POP, 16'h0000, 16'h0000, 32'h0, 1'b1, ST_EMPTY, 16'h0, 16'h0, 32'h0, 5'd0},
		// fill the store out of order: ties on cost, ident extremes
		'{OP_INSERT, 16'h0100, 16'h0005, 32'hA5A5_A5A5, 1'b0, ST_INSERTED, '0, '0, '0, '0},
		'{OP_INSERT, 16'h0100, 16'h0003, 32'h5A5A_5A5A, 1'b0, ST_INSERTED, '0, '0, '0, '0},
		'{OP_INSERT, 16'h00FF, 16'hFFFF, 32'h0000_0001, 1'b0, ST_INSERTED, '0, '0, '0, '0},
		'{OP_INSERT, 16'h0100, 16'h0004, 32'h8000_0000, 1'b0, ST_INSERTED, '0, '0, '0, '0},
		'{OP_INSERT, 16'h8000, 16'h0001, 32'h1234_5678, 1'b0, ST_INSERTED, '0, '0, '0, '0},
		'{OP_INSERT, 16'h0001, 16'h8000, 32'h8765_4321, 1'b0, ST_INSERTED, '0, '0, '0, '0},
		'{OP_INSERT, 16'h0100, 16'h0002, 32'hDEAD_BEEF, 1'b0, ST_INSERTED, '0, '0, '0, '0},
		'{OP_INSERT, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF, 1'b0, ST_INSERTED, '0, '0, '0, '0},
		'{OP_INSERT, 16'h0100, 16'h0006, 32'h0F0F_0F0F, 1'b0, ST_INSERTED, '0, '0, '0, '0},
		'{OP_INSERT, 16'h0002, 16'h0000, 32'hF0F0_F0F0, 1'b0, ST_INSERTED, '0, '0, '0, '0},
		'{OP_INSERT, 16'hFFFE, 16'h0001, 32'h0000_FFFF, 1'b0, ST_INSERTED, '0, '0, '0, '0},
		'{OP_INSERT, 16'h0100, 16'h0001, 32'hFFFF_0000, 1'b0, ST_INSERTED, '0, '0, '0, '0},
		'{OP_INSERT, 16'h0003, 16'h0000, 32'h3333_3333, 1'b0, ST_INSERTED, '0, '0, '0, '0},
		'{OP_INSERT, 16'h0100, 16'h0007, 32'hCCCC_CCCC, 1'b0, ST_INSERTED, '0, '0, '0, '0},
		'{OP_INSERT, 16'h5555, 16'hAAAA, 32'h5555_5555, 1'b0, ST_INSERTED, '0, '0, '0, '0},
		'{OP_INSERT, 16'hAAAA, 16'h5555, 32'hAAAA_AAAA, 1'b0, ST_INSERTED, '0, '0, '0, '0},
		// new key into a full store: dropped
		'{OP_INSERT, 16'h0200, 16'h0000, 32'h1111_1111,
			1'b1, ST_FULL, 16'h0, 16'h0, 32'h0, 5'd16},
		// stored key into a full store: the duplicate wins over full
		'{OP_INSERT, 16'h0100, 16'h0005, 32'h2222_2222,
			1'b1, ST_DUPLICATE, 16'h0, 16'h0, 32'h0, 5'd16}
	};

	min_priority_queue_f_then_id #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Hard stop in case a handshake never completes
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	// Apply one item to the open list and return the result it gives
	function automatic qresult_t open_list_step(op_t op, logic [COST_W-1:0] cost,
			logic [IDENT_W-1:0] ident, logic [PAYLOAD_W-1:0] payload);
		qresult_t res;
		entry_t ent;
		int pos;

		res = '{ST_INSERTED, '0, '0, '0, '0};
		if (op == OP_INSERT) begin
			ent.cost = cost;
			ent.ident = ident;
			ent.payload = payload;
			pos = 0;
			// advance to the first entry not below the new key
			while (pos < open_list.size() &&
					{open_list[pos].cost, open_list[pos].ident} < {cost, ident})
				pos++;
			if (pos < open_list.size() &&
					{open_list[pos].cost, open_list[pos].ident} == {cost, ident})
				res.status = ST_DUPLICATE;
			else if (open_list.size() >= CAPACITY)
				res.status = ST_FULL;
			else begin
				open_list.insert(pos, ent);
				res.status = ST_INSERTED;
			end
		end else if (open_list.size() == 0) begin
			res.status = ST_EMPTY;
		end else begin
			ent = open_list.pop_front();
			res.status = ST_POPPED;
			res.cost = ent.cost;
			res.ident = ent.ident;
			res.payload = ent.payload;
		end
		res.occ = OCC_W'(open_list.size());
		return res;
	endfunction

	// Offer one item, hold it until the transfer, then book its result.
	// A typed row supplies its own result; the list is still updated.
	task automatic offer_item(op_t op, logic [COST_W-1:0] cost,
			logic [IDENT_W-1:0] ident, logic [PAYLOAD_W-1:0] payload,
			bit typed, qresult_t typed_res);
		qresult_t res;

		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {payload, ident, cost};
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		res = open_list_step(op, cost, ident, payload);
		pending_results.push_back(typed ? typed_res : res);
	endtask

	// Receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Result checker: compare every result transfer with the oldest expectation
	always @(posedge clk) begin
		qresult_t want;

		if (arst_n && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (pending_results.size() == 0) begin
				if (fault_count < MAX_REPORTS)
					$display("unexpected result: status %0d tdata %h", m_tuser, m_tdata);
				fault_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status ||
						m_tdata[15:0] !== want.cost ||
						m_tdata[31:16] !== want.ident ||
						m_tdata[63:32] !== want.payload ||
						m_tdata[64 +: OCC_W] !== want.occ) begin
					if (fault_count < MAX_REPORTS) begin
						$display("mismatch: expected status %0d cost %h ident %h payload %h occ %0d",
							want.status, want.cost, want.ident, want.payload,
							want.occ);
						$display("          got status %0d cost %h ident %h payload %h occ %0d",
							m_tuser, m_tdata[15:0], m_tdata[31:16], m_tdata[63:32],
							m_tdata[64 +: OCC_W]);
					end
					fault_count++;
				end
			end
		end
	end

	// Stimulus and end of run
	initial begin
		qresult_t typed_res;
		qresult_t no_res;
		logic [COST_W-1:0] cost;
		logic [IDENT_W-1:0] ident;
		int pop_pct;
		int drain;

		no_res = '{ST_INSERTED, '0, '0, '0, '0};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed table
		foreach (directed_rows[i]) begin
			typed_res = '{directed_rows[i].status, directed_rows[i].r_cost,
				directed_rows[i].r_ident, directed_rows[i].r_payload,
				directed_rows[i].r_occ};
			offer_item(directed_rows[i].op, directed_rows[i].cost,
				directed_rows[i].ident, directed_rows[i].payload,
				directed_rows[i].typed, typed_res);
		end

		// Random part: four idling phases
		pop_pct = 50;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
					// stall the result stream so the block backs up
					hold_requests++;
				end
				1: begin
					send_idle_pct = 81;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 81;
				end
				default: begin
					send_idle_pct = 31;
					recv_stall_pct = 31;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// drift the insert/pop mix so the list fills and drains
				if (n % 40 == 0)
					pop_pct = 25 * $urandom_range(1, 3);
				// a small key pool makes duplicates and full stores common
				if ($urandom_range(0, 99) < 40) begin
					cost = COST_W'($urandom_range(0, 3));
					ident = IDENT_W'($urandom_range(0, 3));
				end else begin
					cost = COST_W'($urandom_range(0, 65535));
					ident = IDENT_W'($urandom_range(0, 65535));
				end
				offer_item(($urandom_range(0, 99) < pop_pct) ? OP_POP : OP_INSERT,
					cost, ident, $urandom, 1'b0, no_res);
			end
		end
		s_tvalid <= 1'b0;

		// Drain outstanding results, then let the block settle
		for (drain = 0; drain < 50000 && pending_results.size() != 0; drain++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			if (fault_count < MAX_REPORTS)
				$display("%0d results never arrived", pending_results.size());
			fault_count++;
		end

		if (fault_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
